/* sv/cca_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package cca_pkg;

    localparam int CLUSTER_W       = 12;
    localparam int ENTRY_W         = 32;
    localparam int CLUSTERS_DEF    = 4096;
    localparam int FIRST_CLUSTER   = 2;
    localparam int APB_AW          = 3;
    localparam int APB_DW          = 32;

    localparam logic [CLUSTER_W-1:0] CLUSTER_MAX_RST = 12'd4095;
    localparam logic [ENTRY_W-1:0]   EOC_MARK_RST    = 32'h0FFF_FFF8;

    // register index, taken from paddr above the byte offset
    localparam logic [APB_AW-3:0] REG_CLUSTER_MAX = 1'b0;
    localparam logic [APB_AW-3:0] REG_EOC_MARK    = 1'b1;

    typedef enum logic [1:0] {
        CMD_NEXT  = 2'd0,
        CMD_ALLOC = 2'd1,
        CMD_READ  = 2'd2,
        CMD_WRITE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_GOOD     = 2'd0,
        ST_END      = 2'd1,
        ST_BAD_LINK = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_EVAL,
        S_SCAN,
        S_CLAIM,
        S_LINK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [CLUSTER_W-1:0] cluster_max;
        logic [ENTRY_W-1:0]   eoc_mark;
    } t_cfg;

    typedef struct packed {
        logic clearing;
        logic load;
    } t_ctrl_stat;

endpackage

`default_nettype wire

/* sv/cca_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface cca_req_if import cca_pkg::*; ();
    logic                 valid;
    logic                 ready;
    t_cmd                 cmd;
    logic [CLUSTER_W-1:0] current_cluster;
    logic [ENTRY_W-1:0]   entry_value;
    logic                 is_directory;

    modport source (output valid, cmd, current_cluster, entry_value, is_directory,
                    input ready);
    modport sink   (input valid, cmd, current_cluster, entry_value, is_directory,
                    output ready);
endinterface

`default_nettype wire

/* sv/cca_rsp_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface cca_rsp_if import cca_pkg::*; ();
    logic                 valid;
    logic                 ready;
    t_status              status;
    logic [CLUSTER_W-1:0] new_cluster;
    logic                 chain_started;
    logic                 zero_needed;
    logic [ENTRY_W-1:0]   read_value;

    modport source (output valid, status, new_cluster, chain_started, zero_needed,
                    read_value, input ready);
    modport sink   (input valid, status, new_cluster, chain_started, zero_needed,
                    read_value, output ready);
endinterface

`default_nettype wire

/* sv/cca_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module cca_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* sv/cca_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none

module cca_cfg import cca_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    logic [CLUSTER_W-1:0] r_cluster_max;
    logic [ENTRY_W-1:0]   r_eoc_mark;
    logic [APB_AW-3:0]    reg_sel;

    assign reg_sel = paddr[APB_AW-1:2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cluster_max <= CLUSTER_MAX_RST;
            r_eoc_mark    <= EOC_MARK_RST;
        end else if (psel && penable && pwrite) begin
            case (reg_sel)
                REG_CLUSTER_MAX: r_cluster_max <= pwdata[CLUSTER_W-1:0];
                REG_EOC_MARK:    r_eoc_mark    <= pwdata[ENTRY_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_CLUSTER_MAX: prdata = APB_DW'(r_cluster_max);
            REG_EOC_MARK:    prdata = APB_DW'(r_eoc_mark);
            default:         prdata = '0;
        endcase
    end

    assign o_cfg.cluster_max = r_cluster_max;
    assign o_cfg.eoc_mark    = r_eoc_mark;

endmodule

`default_nettype wire

/* sv/cca_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module cca_ctrl import cca_pkg::*; #(
    parameter int CLUSTERS = CLUSTERS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire t_cfg                        i_cfg,
    cca_req_if.sink                          i_req,
    cca_rsp_if.source                        o_rsp,
    output logic                             o_mem_we,
    output logic [$clog2(CLUSTERS)-1:0]      o_mem_waddr,
    output logic [ENTRY_W-1:0]               o_mem_wdata,
    output logic [$clog2(CLUSTERS)-1:0]      o_mem_raddr,
    input  wire logic [ENTRY_W-1:0]          i_mem_rdata,
    output t_ctrl_stat                       o_stat
);

    localparam int AW = $clog2(CLUSTERS);
    // search arithmetic: wide enough for any cluster number plus one
    localparam int CW = ((AW > CLUSTER_W) ? AW : CLUSTER_W) + 1;
    localparam logic [CW-1:0] FIRST_W = CW'(FIRST_CLUSTER);
    localparam logic [CW-1:0] LAST_W  = CW'(CLUSTERS - 1);

    t_state               r_state, n_state;
    t_cmd                 r_cmd, n_cmd;
    logic [CLUSTER_W-1:0] r_cur, n_cur;
    logic [ENTRY_W-1:0]   r_val, n_val;
    logic                 r_dir, n_dir;
    logic [AW-1:0]        r_clr_idx, n_clr_idx;
    logic [CW-1:0]        r_idx, n_idx;
    logic [CW-1:0]        r_lim2, n_lim2;
    logic                 r_pass2, n_pass2;
    logic                 r_issue, n_issue;
    logic                 r_pend, n_pend;
    logic [AW-1:0]        r_pend_idx, n_pend_idx;
    logic [AW-1:0]        r_found, n_found;

    t_status              r_res_status, n_res_status;
    logic [CLUSTER_W-1:0] r_res_newc, n_res_newc;
    logic                 r_res_started, n_res_started;
    logic                 r_res_zero, n_res_zero;
    logic [ENTRY_W-1:0]   r_res_rd, n_res_rd;

    logic                 r_out_valid, n_out_valid;
    t_status              r_out_status;
    logic [CLUSTER_W-1:0] r_out_newc;
    logic                 r_out_started;
    logic                 r_out_zero;
    logic [ENTRY_W-1:0]   r_out_rd;

    logic [CW-1:0]        cur_ext, cmax_ext, m_ext, m_inc, start_ext, lim2_ext;
    logic [CW-1:0]        idx_inc, found_ext;
    logic [AW-1:0]        cur_idx;
    logic                 in_tbl, pass1_on, pass2_on, scan_last, load;
    logic [ENTRY_W-1:0]   entry, m_entry;
    t_status              follow_st;

    assign cur_ext   = CW'(r_cur);
    assign cur_idx   = cur_ext[AW-1:0];
    assign in_tbl    = cur_ext < CW'(CLUSTERS);
    assign cmax_ext  = CW'(i_cfg.cluster_max);
    assign m_ext     = (cmax_ext > LAST_W) ? LAST_W : cmax_ext;
    assign m_inc     = m_ext + CW'(1);
    assign m_entry   = ENTRY_W'(m_ext);
    assign start_ext = (cur_ext < FIRST_W) ? FIRST_W : cur_ext + CW'(1);
    assign lim2_ext  = (cur_ext < FIRST_W) ? FIRST_W :
                       ((cur_ext < m_inc) ? cur_ext : m_inc);
    assign pass1_on  = start_ext <= m_ext;
    assign pass2_on  = lim2_ext > FIRST_W;
    assign idx_inc   = r_idx + CW'(1);
    assign scan_last = r_pass2 ? (idx_inc >= r_lim2) : (r_idx == m_ext);
    assign found_ext = CW'(r_found);
    assign entry     = in_tbl ? i_mem_rdata : '0;

    always_comb begin
        if (entry >= i_cfg.eoc_mark) begin
            follow_st = ST_END;
        end else if (entry > m_entry || entry < ENTRY_W'(FIRST_CLUSTER)) begin
            follow_st = ST_BAD_LINK;
        end else begin
            follow_st = ST_GOOD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_issue     <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_issue     <= n_issue;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd         <= n_cmd;
        r_cur         <= n_cur;
        r_val         <= n_val;
        r_dir         <= n_dir;
        r_idx         <= n_idx;
        r_lim2        <= n_lim2;
        r_pass2       <= n_pass2;
        r_pend_idx    <= n_pend_idx;
        r_found       <= n_found;
        r_res_status  <= n_res_status;
        r_res_newc    <= n_res_newc;
        r_res_started <= n_res_started;
        r_res_zero    <= n_res_zero;
        r_res_rd      <= n_res_rd;
        if (load) begin
            r_out_status  <= r_res_status;
            r_out_newc    <= r_res_newc;
            r_out_started <= r_res_started;
            r_out_zero    <= r_res_zero;
            r_out_rd      <= r_res_rd;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_cmd         = r_cmd;
        n_cur         = r_cur;
        n_val         = r_val;
        n_dir         = r_dir;
        n_clr_idx     = r_clr_idx;
        n_idx         = r_idx;
        n_lim2        = r_lim2;
        n_pass2       = r_pass2;
        n_issue       = r_issue;
        n_pend        = r_pend;
        n_pend_idx    = r_pend_idx;
        n_found       = r_found;
        n_res_status  = r_res_status;
        n_res_newc    = r_res_newc;
        n_res_started = r_res_started;
        n_res_zero    = r_res_zero;
        n_res_rd      = r_res_rd;
        o_mem_we      = 1'b0;
        o_mem_waddr   = cur_idx;
        o_mem_wdata   = r_val;
        o_mem_raddr   = (r_state == S_SCAN && r_issue) ? r_idx[AW-1:0] : cur_idx;
        load          = 1'b0;

        case (r_state)
            S_CLEAR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_clr_idx;
                o_mem_wdata = '0;
                n_clr_idx   = r_clr_idx + AW'(1);
                if (r_clr_idx == AW'(CLUSTERS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_cmd         = i_req.cmd;
                    n_cur         = i_req.current_cluster;
                    n_val         = i_req.entry_value;
                    n_dir         = i_req.is_directory;
                    n_res_status  = ST_GOOD;
                    n_res_newc    = i_req.current_cluster;
                    n_res_started = 1'b0;
                    n_res_zero    = 1'b0;
                    n_res_rd      = '0;
                    n_state       = S_LOOK;
                end
            end
            S_LOOK: begin
                // read of the current entry goes out here
                if (r_cmd == CMD_WRITE) begin
                    o_mem_we = in_tbl;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = S_DONE;
                case (r_cmd)
                    CMD_READ: begin
                        n_res_rd = entry;
                    end
                    CMD_NEXT: begin
                        n_res_status = follow_st;
                        if (follow_st == ST_GOOD) begin
                            n_res_newc = entry[CLUSTER_W-1:0];
                        end
                    end
                    CMD_ALLOC: begin
                        if (cur_ext >= FIRST_W && entry < i_cfg.eoc_mark) begin
                            n_res_status = follow_st;
                            if (follow_st == ST_GOOD) begin
                                n_res_newc = entry[CLUSTER_W-1:0];
                            end
                        end else if (pass1_on || pass2_on) begin
                            n_idx   = pass1_on ? start_ext : FIRST_W;
                            n_pass2 = !pass1_on;
                            n_lim2  = lim2_ext;
                            n_issue = 1'b1;
                            n_pend  = 1'b0;
                            n_state = S_SCAN;
                        end else begin
                            n_res_status = ST_FULL;
                        end
                    end
                    default: ;
                endcase
            end
            S_SCAN: begin
                if (r_pend && i_mem_rdata == '0) begin
                    n_found = r_pend_idx;
                    n_issue = 1'b0;
                    n_pend  = 1'b0;
                    n_state = S_CLAIM;
                end else if (!r_issue) begin
                    n_pend       = 1'b0;
                    n_res_status = ST_FULL;
                    n_state      = S_DONE;
                end else begin
                    n_pend     = 1'b1;
                    n_pend_idx = r_idx[AW-1:0];
                    if (scan_last) begin
                        if (!r_pass2 && r_lim2 > FIRST_W) begin
                            n_idx   = FIRST_W;
                            n_pass2 = 1'b1;
                        end else begin
                            n_issue = 1'b0;
                        end
                    end else begin
                        n_idx = idx_inc;
                    end
                end
            end
            S_CLAIM: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_found;
                o_mem_wdata = i_cfg.eoc_mark;
                n_res_newc  = found_ext[CLUSTER_W-1:0];
                n_res_zero  = r_dir;
                if (cur_ext >= FIRST_W) begin
                    n_state = S_LINK;
                end else begin
                    n_res_started = 1'b1;
                    n_state       = S_DONE;
                end
            end
            S_LINK: begin
                o_mem_we    = in_tbl;
                o_mem_waddr = cur_idx;
                o_mem_wdata = ENTRY_W'(found_ext);
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    load    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (load) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign i_req.ready         = (r_state == S_IDLE);
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.new_cluster   = r_out_newc;
    assign o_rsp.chain_started = r_out_started;
    assign o_rsp.zero_needed   = r_out_zero;
    assign o_rsp.read_value    = r_out_rd;

    assign o_stat.clearing = (r_state == S_CLEAR);
    assign o_stat.load     = load;

endmodule

`default_nettype wire

/* sv/cluster_chain_allocator.sv */
// write: the table is written in the lookup state, then the result goes to the output register
// next/read: the entry is read in the lookup state and evaluated, then goes to the output register
// allocate with a free search: a scan through the single read port of the link table, then claim and link writes
// one command is in work at a time; a finished result waits in the output register
// reset (synchronous, active low): registers to defaults, then a clearing pass zeroes the
// whole link table while no transaction is accepted
`timescale 1ns / 1ps
`default_nettype none

module cluster_chain_allocator import cca_pkg::*; #(
    parameter int CLUSTERS = CLUSTERS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    cca_req_if.sink                i_req,
    cca_rsp_if.source              o_rsp,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    localparam int AW = $clog2(CLUSTERS);

    t_cfg                cfg;
    t_ctrl_stat          stat;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [ENTRY_W-1:0]  mem_wdata;
    logic [AW-1:0]       mem_raddr;
    logic [ENTRY_W-1:0]  mem_rdata;

    // register file: cluster_max at offset 0, end-of-chain mark at offset 4
    cca_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // link table, one entry per cluster, registered read
    cca_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CLUSTERS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // sequencer: clearing pass, lookup, next-fit scan, claim and link writes,
    // plus the output register that holds a finished result
    cca_ctrl #(
        .CLUSTERS (CLUSTERS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata),
        .o_stat      (stat)
    );

    // no command gets in while the table is still being cleared
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.clearing |-> !(i_req.valid && i_req.ready))
        else $error("transaction accepted during table clear");

    // a new result never overwrites one that was not taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.load |-> (!o_rsp.valid || o_rsp.ready))
        else $error("pending result overwritten");

    // a fresh chain always reports success with a real cluster number
    a_started_good: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.chain_started) |->
            (o_rsp.status == ST_GOOD &&
             o_rsp.new_cluster >= CLUSTER_W'(FIRST_CLUSTER)))
        else $error("chain start with bad status or cluster");

    // any flag set means the command claimed a cluster, so no read data
    a_flags_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.chain_started || o_rsp.zero_needed)) |->
            (o_rsp.read_value == '0 && o_rsp.status == ST_GOOD))
        else $error("allocation flags with read data or failure");

endmodule

`default_nettype wire
